### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the histogram percentile block.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");
`define ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");
`else
`define ASSERT_IMP(name, clk, rst_n, ante, cons)
`define ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

### rtl/hpe_pkg.sv
// Package for the histogram percentile estimator: widths, codes and states.
// Depends on nothing; imported by histogram_percentile_estimator.
`timescale 1ns / 1ps
`default_nettype none
package hpe_pkg;
	localparam int NUM_BINS = 1024;
	localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int CNT_W = $clog2(BIN_W + 1);
	localparam int DATA_W = 32;
	localparam int PCT_W = 7;
	localparam int FUNC_W = 2;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 1;
	localparam int PROD_W = DATA_W + PCT_W;
	localparam int ACC_W = PROD_W + BIN_W;
	localparam int DIV_W = DATA_W + BIN_W - 1;

	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
	localparam logic [DATA_W-1:0] BIN_WIDTH_RST = 32'd1;
	localparam logic [DATA_W-1:0] MAX_RANGE_RST = 32'd1024;
	localparam logic [DATA_W-1:0] COUNT_MAX = '1;
	localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

	localparam logic [FUNC_W-1:0] FUNC_ADD = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BAD_PCT = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE = 1'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLR,
		ST_DCHK,
		ST_DIV,
		ST_RD,
		ST_WR,
		ST_QPREP,
		ST_SCAN
	} state_t;
endpackage
`default_nettype wire

### rtl/histogram_percentile_estimator.sv
// Histogram percentile estimator: bin store in one RAM, adds by read-modify-write.
// Depends on hpe_pkg and assert_macros.svh.
// Add: 10-step restoring divide for the bin (skipped on overflow, which picks the last bin), then RAM read and write.
// Query: bad percent or empty histogram is answered without a scan; otherwise a RAM scan of up
// to all NUM_BINS bins, one bin per cycle through the read port and the running sum.
// Clear: one RAM word per cycle over all NUM_BINS words. After reset the same clearing pass
// runs over all NUM_BINS words before the first word is accepted; config writes are always taken.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module histogram_percentile_estimator (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [hpe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [hpe_pkg::DATA_W-1:0]     cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [hpe_pkg::FUNC_W-1:0]     func,
	input  wire logic [hpe_pkg::DATA_W-1:0]     sample_value,
	input  wire logic [hpe_pkg::PCT_W-1:0]      percent,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [hpe_pkg::DATA_W-1:0]          percentile_value,
	output logic [hpe_pkg::STATUS_W-1:0]        status
);
	import hpe_pkg::*;

	state_t state_q, state_d;

	logic [DATA_W-1:0] bin_width_q, max_range_q, total_q;
	logic [DATA_W-1:0] limit, clamped, eff_width;
	logic pct_bad, accept, out_load, result_now;

	logic [DATA_W-1:0] rem_q, w_q;
	logic [DIV_W-1:0] d_q;
	logic [BIN_W-1:0] q_q, bin_sel, bin_q, addr_q;
	logic [CNT_W-1:0] cnt_q;
	logic div_ovf, div_bit;

	logic [PCT_W-1:0] pct_q;
	logic [PROD_W-1:0] prod, thr_q;
	logic issued_all_q, scan_issue, hit, scan_miss;
	logic v_s1, v_s2, v_s3;
	logic [BIN_W-1:0] idx_s1, idx_s2, idx_s3;
	logic [DATA_W-1:0] rdata_s1;
	logic [PROD_W-1:0] m_s2;
	logic [ACC_W-1:0] acc_q;

	logic [DATA_W-1:0] res_value_q, value_q;
	logic [STATUS_W-1:0] res_status_q, status_q;
	logic res_pending_q, out_valid_q;

	logic mem_we, mem_re;
	logic [BIN_W-1:0] mem_waddr, mem_raddr;
	logic [DATA_W-1:0] mem_wdata;
	logic [DATA_W-1:0] bin_mem [NUM_BINS];

	assign in_ready = (state_q == ST_IDLE) && !res_pending_q;
	assign accept = in_valid && in_ready;
	assign limit = (max_range_q == '0) ? '0 : max_range_q - 1'b1;
	assign clamped = (sample_value > limit) ? limit : sample_value;
	assign eff_width = (bin_width_q == '0) ? BIN_WIDTH_RST : bin_width_q;
	assign pct_bad = (percent == '0) || (percent > PCT_FULL);

	assign div_ovf = (rem_q >> BIN_W) >= w_q;
	assign div_bit = DIV_W'(rem_q) >= d_q;
	assign bin_sel = (q_q > LAST_BIN) ? LAST_BIN : q_q;

	assign prod = PROD_W'(pct_q) * PROD_W'(total_q);
	assign scan_issue = (state_q == ST_SCAN) && !issued_all_q;
	assign hit = (state_q == ST_SCAN) && v_s3 && (acc_q > ACC_W'(thr_q));
	assign scan_miss = (state_q == ST_SCAN) && v_s3 && !hit && (idx_s3 == LAST_BIN);
	assign result_now = hit || scan_miss;

	assign mem_we = (state_q == ST_CLR) || (state_q == ST_WR);
	assign mem_waddr = (state_q == ST_CLR) ? addr_q : bin_q;
	assign mem_wdata = (state_q == ST_CLR) ? '0 :
		((rdata_s1 == COUNT_MAX) ? rdata_s1 : rdata_s1 + 1'b1);
	assign mem_re = (state_q == ST_RD) || scan_issue;
	assign mem_raddr = (state_q == ST_RD) ? bin_sel : addr_q;

	assign out_load = res_pending_q && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign percentile_value = value_q;
	assign status = status_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			bin_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_s1 <= bin_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (func)
						FUNC_ADD: state_d = ST_DCHK;
						FUNC_QUERY: begin
							if (!pct_bad && (total_q != '0)) begin
								state_d = ST_QPREP;
							end
						end
						FUNC_CLEAR: state_d = ST_CLR;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_CLR: begin
				if (addr_q == LAST_BIN) begin
					state_d = ST_IDLE;
				end
			end
			ST_DCHK: state_d = div_ovf ? ST_RD : ST_DIV;
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_RD;
				end
			end
			ST_RD: state_d = ST_WR;
			ST_WR: state_d = ST_IDLE;
			ST_QPREP: state_d = ST_SCAN;
			ST_SCAN: begin
				if (result_now) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_width_q <= BIN_WIDTH_RST;
			max_range_q <= MAX_RANGE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BIN_WIDTH: bin_width_q <= cfg_data;
				REG_MAX_RANGE: max_range_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			addr_q <= '0;
			issued_all_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			res_pending_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= scan_issue;
			v_s2 <= v_s1 && (state_q == ST_SCAN) && !result_now;
			v_s3 <= v_s2 && (state_q == ST_SCAN) && !result_now;
			if (state_q == ST_CLR) begin
				total_q <= '0;
				addr_q <= (addr_q == LAST_BIN) ? '0 : addr_q + 1'b1;
			end else if (state_q == ST_WR) begin
				if (total_q != COUNT_MAX) begin
					total_q <= total_q + 1'b1;
				end
			end else if (state_q == ST_QPREP) begin
				addr_q <= '0;
				issued_all_q <= 1'b0;
			end else if (scan_issue) begin
				addr_q <= (addr_q == LAST_BIN) ? '0 : addr_q + 1'b1;
				issued_all_q <= (addr_q == LAST_BIN);
			end else if (accept && (func == FUNC_CLEAR)) begin
				addr_q <= '0;
			end
			if ((accept && (func == FUNC_QUERY) && (pct_bad || (total_q == '0))) ||
				result_now) begin
				res_pending_q <= 1'b1;
			end else if (out_load) begin
				res_pending_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rem_q <= clamped;
			w_q <= eff_width;
			pct_q <= percent;
			res_value_q <= '0;
			res_status_q <= pct_bad ? STATUS_BAD_PCT : STATUS_EMPTY;
		end
		if (state_q == ST_DCHK) begin
			q_q <= div_ovf ? '1 : '0;
			d_q <= DIV_W'(w_q) << (BIN_W - 1);
			cnt_q <= CNT_W'(BIN_W - 1);
		end
		if (state_q == ST_DIV) begin
			if (div_bit) begin
				rem_q <= DATA_W'(DIV_W'(rem_q) - d_q);
			end
			q_q <= (q_q << 1) | BIN_W'(div_bit);
			d_q <= d_q >> 1;
			cnt_q <= cnt_q - 1'b1;
		end
		if (state_q == ST_RD) begin
			bin_q <= bin_sel;
		end
		if (state_q == ST_QPREP) begin
			thr_q <= (prod >= PROD_W'(PCT_FULL)) ? prod - PROD_W'(PCT_FULL) : '0;
			acc_q <= '0;
		end
		idx_s1 <= addr_q;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		m_s2 <= PROD_W'(rdata_s1) * PROD_W'(PCT_FULL);
		if (v_s2 && (state_q == ST_SCAN)) begin
			acc_q <= acc_q + ACC_W'(m_s2);
		end
		if (hit) begin
			res_value_q <= DATA_W'(DATA_W'(idx_s3) * bin_width_q);
			res_status_q <= STATUS_OK;
		end else if (scan_miss) begin
			res_value_q <= '0;
			res_status_q <= STATUS_EMPTY;
		end
		if (out_load) begin
			value_q <= res_value_q;
			status_q <= res_status_q;
		end
	end

	`ASSERT_IMP(a_mem_one_access, clk, arst_n, mem_we, !mem_re)
	`ASSERT_NXT(a_wr_counts, clk, arst_n, state_q == ST_WR, total_q != '0)
	`ASSERT_NXT(a_hit_ok, clk, arst_n, hit, res_pending_q && (res_status_q == STATUS_OK))
	`ASSERT_IMP(a_no_accept_pending, clk, arst_n, res_pending_q, !in_ready)
	`ASSERT_NXT(a_load_shows, clk, arst_n, out_load, out_valid_q)
endmodule
`default_nettype wire
